@@ rtl/stld_pkg.sv @@
// ---------------------------------------------------------------------------
// stld_pkg
// shared types and constants of the sync/type/length deframer
// ---------------------------------------------------------------------------
`default_nettype none

package stld_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned TypeW  = 16;
    localparam int unsigned LenW   = 32;
    localparam int unsigned CfgIdxW = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgMaxPayload = 2'd2;

    // reset values of the configuration registers
    localparam logic [ByteW-1:0] SyncFirstReset  = 8'h12;
    localparam logic [ByteW-1:0] SyncSecondReset = 8'h34;
    localparam logic [LenW-1:0]  MaxPayloadReset = 32'd1048576;

    // live configuration seen by the parser
    typedef struct packed {
        logic [ByteW-1:0] sync_first;
        logic [ByteW-1:0] sync_second;
        logic [LenW-1:0]  max_payload;
    } stld_cfg_t;

    // one result item
    typedef struct packed {
        logic [TypeW-1:0] frame_type;
        logic [LenW-1:0]  payload_length;
        logic [ByteW-1:0] payload_byte;
        logic             has_data;
        logic             last;
        logic             oversize;
    } stld_item_t;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_LEAD = 5'b00010,
        PH_TYPE = 5'b00100,
        PH_SIZE = 5'b01000,
        PH_DATA = 5'b10000
    } stld_phase_t;

endpackage

`default_nettype wire

@@ rtl/sync_type_length_deframer_unit.sv @@
// ---------------------------------------------------------------------------
// sync_type_length_deframer_unit
// byte-serial frame finder for sync / type / length framed link streams
// ---------------------------------------------------------------------------
// One received byte is taken per item, one item per clock cycle. A frame is
// the first sync byte, the second sync byte, a 16-bit big-endian type, a
// 32-bit big-endian payload length and then that many payload bytes. Every
// payload byte gives one result item carrying the type, the length and a
// last flag; an empty frame gives one item with no data, and a frame longer
// than max_payload is dropped with one item that has oversize set. A wrong
// second sync byte sends the parser back to idle without retrying that byte
// as a first sync byte. The parser classifies each byte in the cycle it is
// taken and puts result items into a QUEUE_DEPTH entry queue; an output
// register feeds the result port. Bytes are taken every cycle as long as
// the queue has room, so the sustained rate is one byte per cycle and
// in_ready only drops after the result side has stalled long enough to fill
// the queue. A result goes through a queue entry, then the output register.
// Configuration writes are taken at once on any cycle with cfg_wr_en high.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_type_length_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    // configuration write port
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    // byte input channel
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  data_byte,
    // result channel
    output logic        out_valid,
    input  wire         out_ready,
    output logic [15:0] frame_type,
    output logic [31:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        has_data,
    output logic        last,
    output logic        oversize
);
    import stld_pkg::*;

    // configuration registers
    stld_cfg_t  cfg_reg;

    // front to queue
    logic       take;
    logic       push;
    stld_item_t push_item;

    // queue to back
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    stld_item_t q_head;
    stld_item_t out_item;

    // a byte is only taken when the queue can hold whatever it may produce
    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SyncFirstReset;
            cfg_reg.sync_second <= SyncSecondReset;
            cfg_reg.max_payload <= MaxPayloadReset;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CfgSyncFirst:  cfg_reg.sync_first  <= cfg_data[ByteW-1:0];
                CfgSyncSecond: cfg_reg.sync_second <= cfg_data[ByteW-1:0];
                CfgMaxPayload: cfg_reg.max_payload <= cfg_data;
                default:       cfg_reg <= cfg_reg;  // unused index
            endcase
        end
    end

    // parser: phase, header bytes and payload count
    stld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    stld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // output register
    stld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    assign frame_type     = out_item.frame_type;
    assign payload_length = out_item.payload_length;
    assign payload_byte   = out_item.payload_byte;
    assign has_data       = out_item.has_data;
    assign last           = out_item.last;
    assign oversize       = out_item.oversize;

endmodule

`default_nettype wire

@@ rtl/stld_front.sv @@
// ---------------------------------------------------------------------------
// stld_front
// frame parser: takes one byte per accepted item and classifies it
// ---------------------------------------------------------------------------
`default_nettype none

module stld_front (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      take,
    input  wire [7:0]                data_byte,
    input  stld_pkg::stld_cfg_t      cfg,
    output logic                     push,
    output stld_pkg::stld_item_t     push_item
);
    import stld_pkg::*;

    stld_phase_t       phase_reg, phase_next;
    logic [1:0]        hcnt_reg, hcnt_next;
    logic [TypeW-1:0]  type_reg, type_next;
    logic [LenW-1:0]   length_reg, length_next;
    logic [LenW-1:0]   pcnt_reg, pcnt_next;
    logic [LenW-1:0]   pcnt_inc;

    assign pcnt_inc = pcnt_reg + 32'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        type_next   = type_reg;
        length_next = length_reg;
        pcnt_next   = pcnt_reg;
        push        = 1'b0;
        push_item   = '0;
        push_item.frame_type     = type_reg;
        push_item.payload_length = length_reg;
        if (take)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    hcnt_next = '0;
                    pcnt_next = '0;
                    phase_next = (data_byte == cfg.sync_second) ? PH_TYPE : PH_IDLE;
                end
                PH_TYPE:
                begin
                    type_next = {type_reg[ByteW-1:0], data_byte};
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == 2'd1)
                    begin
                        phase_next = PH_SIZE;
                        hcnt_next  = '0;
                    end
                end
                PH_SIZE:
                begin
                    length_next = {length_reg[LenW-ByteW-1:0], data_byte};
                    hcnt_next   = hcnt_reg + 2'd1;
                    push_item.payload_length = length_next;
                    if (hcnt_reg == 2'd3)
                    begin
                        hcnt_next = '0;
                        pcnt_next = '0;
                        if (length_next == '0)
                        begin
                            // empty frame: one item with no data
                            push           = 1'b1;
                            push_item.last = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                        else if (length_next > cfg.max_payload)
                        begin
                            push               = 1'b1;
                            push_item.last     = 1'b1;
                            push_item.oversize = 1'b1;
                            phase_next         = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    push                   = 1'b1;
                    push_item.payload_byte = data_byte;
                    push_item.has_data     = 1'b1;
                    push_item.last         = (pcnt_inc == length_reg);
                    pcnt_next              = pcnt_inc;
                    if (pcnt_inc == length_reg)
                    begin
                        phase_next = PH_IDLE;
                        hcnt_next  = '0;
                        pcnt_next  = '0;
                    end
                end
                default:
                begin
                    // idle and any stray code
                    hcnt_next   = '0;
                    pcnt_next   = '0;
                    length_next = '0;
                    phase_next  = (data_byte == cfg.sync_first) ? PH_LEAD : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hcnt_reg   <= '0;
            pcnt_reg   <= '0;
            type_reg   <= '0;
            length_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            pcnt_reg   <= pcnt_next;
            type_reg   <= type_next;
            length_reg <= length_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/stld_queue.sv @@
// ---------------------------------------------------------------------------
// stld_queue
// short register queue between parser and output stage
// ---------------------------------------------------------------------------
`default_nettype none

module stld_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  stld_pkg::stld_item_t     push_item,
    input  wire                      pop,
    output logic                     full,
    output logic                     not_empty,
    output stld_pkg::stld_item_t     head
);
    import stld_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    stld_item_t      entry_reg [DEPTH];
    logic [PtrW-1:0] wptr_reg, wptr_next;
    logic [PtrW-1:0] rptr_reg, rptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == FullCnt);
    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == LastPtr) ? '0 : wptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LastPtr) ? '0 : rptr_reg + PtrW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CntW'(1);
            2'b01:   cnt_next = cnt_reg - CntW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/stld_back.sv @@
// ---------------------------------------------------------------------------
// stld_back
// output stage: moves queued items into the output register
// ---------------------------------------------------------------------------
`default_nettype none

module stld_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      q_not_empty,
    input  stld_pkg::stld_item_t     q_head,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire                      out_ready,
    output stld_pkg::stld_item_t     out_item
);
    import stld_pkg::*;

    logic       valid_reg, valid_next;
    stld_item_t item_reg;

    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_head;
        end
    end

endmodule

`default_nettype wire
